>>> rtl/isrn_pkg.sv
// Package for the integer square root block.
// Holds the datapath widths and the controller state type; no dependencies.
`default_nettype none
package isrn_pkg;

	localparam int RAD_W   = 32;
	localparam int ROOT_W  = 16;
	// The estimate and the divider run one bit wider than the radicand so that
	// the rounded-up dividend of the last step never wraps.
	localparam int Z_W     = RAD_W + 1;
	localparam int REST_W  = RAD_W - 2;
	localparam int CNT_W   = $clog2(Z_W);
	localparam int STEP_W  = 2;

	localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(Z_W - 1);
	localparam logic [STEP_W-1:0] STEP_CEIL = STEP_W'(3);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GUESS,
		ST_LOAD,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} isrn_state_t;

endpackage
`default_nettype wire

>>> rtl/integer_square_root_newton.sv
// Integer square root by a fixed Newton schedule on a bit-serial divider; uses isrn_pkg.
// A zero radicand goes straight to the finish state. Otherwise the guess state shifts
// two radicand bits per step, then four divisions run on one restoring divider (load,
// 33 quotient bits, update each), and the finish state loads the output register once it is free.
// s_tready is high only in idle; the next beat is taken while a root waits on m_tready.
// Reset: arst_n clears the controller and the output valid flag at once.
`default_nettype none
module integer_square_root_newton
	import isrn_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [RAD_W-1:0]  s_tdata,   // [31:0] radicand
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [ROOT_W-1:0]      m_tdata    // [15:0] root
);

	isrn_state_t state_q, state_next;

	logic [RAD_W-1:0]  x_q;
	logic [REST_W-1:0] rest_q;
	logic [Z_W-1:0]    z_q;
	logic [Z_W-1:0]    rem_q;
	logic [Z_W-1:0]    quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] step_q;
	logic [ROOT_W-1:0] out_q;
	logic              out_valid_q;

	logic              in_beat;
	logic              finish_go;
	logic [Z_W-1:0]    dividend;
	logic [Z_W:0]      rem_shift;
	logic [Z_W+1:0]    trial;
	logic              borrow;
	logic [Z_W:0]      z_sum;
	logic [ROOT_W-1:0] root_sat;

	assign in_beat = s_tvalid && s_tready;

	// The last step rounds the quotient up by dividing x + z - 1.
	assign dividend = (step_q == STEP_CEIL) ?
		Z_W'({1'b0, x_q} + z_q - Z_W'(1)) : Z_W'(x_q);

	assign rem_shift = {rem_q, quo_q[Z_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, z_q};
	assign borrow    = trial[Z_W+1];
	assign z_sum     = {1'b0, z_q} + {1'b0, quo_q};
	assign root_sat  = (|z_q[Z_W-1:ROOT_W]) ? {ROOT_W{1'b1}} : z_q[ROOT_W-1:0];

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		finish_go = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
		m_tvalid  = out_valid_q;
		m_tdata   = out_q;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_next = (s_tdata == '0) ? ST_FINISH : ST_GUESS;
				end
			end
			ST_GUESS: begin
				if (rest_q == '0) begin
					state_next = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_next = (step_q == STEP_CEIL) ? ST_FINISH : ST_LOAD;
			end
			ST_FINISH: begin
				if (finish_go) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					x_q    <= s_tdata;
					rest_q <= s_tdata[RAD_W-1:2];
					z_q    <= (s_tdata == '0) ? '0 : Z_W'(1);
					step_q <= '0;
				end
			end
			ST_GUESS: begin
				if (rest_q != '0) begin
					rest_q <= rest_q >> 2;
					z_q    <= z_q << 1;
				end
			end
			ST_LOAD: begin
				quo_q <= dividend;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= borrow ? rem_shift[Z_W-1:0] : trial[Z_W-1:0];
				quo_q <= {quo_q[Z_W-2:0], ~borrow};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_UPDATE: begin
				z_q    <= z_sum[Z_W:1];
				step_q <= step_q + STEP_W'(1);
			end
			ST_FINISH: begin
				if (finish_go) begin
					out_q <= root_sat;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_zero_short: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tdata == '0) |=> (state_q == ST_FINISH && z_q == '0))
		else $error("zero radicand did not go straight to finish");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (z_q != '0))
		else $error("divider started with a zero divisor");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider bit count overran");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished root not presented on the output");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for integer_square_root_newton: directed and random radicands
// with random source gaps and sink stalls, each root checked against a Newton schedule model.
// Depends on isrn_pkg and the integer_square_root_newton RTL.
`default_nettype none
module tb_top;
	import isrn_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LINGER     = 200;
	localparam int N_RANDOM   = 650;

	class root_scoreboard;
		bit [ROOT_W-1:0] pending_roots[$];
		bit [RAD_W-1:0]  pending_rads[$];
		int              error_count;

		function new();
			error_count = 0;
		endfunction

		function bit [ROOT_W-1:0] newton_root(bit [RAD_W-1:0] radicand);
			bit [63:0] x;
			bit [63:0] z;
			bit [63:0] rest;
			x = radicand;
			if (x == 0) begin
				return '0;
			end
			rest = x >> 2;
			z = 1;
			while (rest != 0) begin
				rest = rest >> 2;
				z = z << 1;
			end
			repeat (3) z = (z + ((z != 0) ? x / z : x)) >> 1;
			z = (z + ((z != 0) ? (x + z - 1) / z : x + z - 1)) >> 1;
			if (z > 64'd65535) begin
				return 16'hFFFF;
			end
			return z[ROOT_W-1:0];
		endfunction

		task report(string msg);
			$display("MISMATCH %0t: %s", $time, msg);
			error_count++;
		endtask

		function void note_input(bit [RAD_W-1:0] radicand);
			pending_rads.push_back(radicand);
			pending_roots.push_back(newton_root(radicand));
		endfunction

		task check_result(bit [ROOT_W-1:0] root);
			bit [ROOT_W-1:0] want;
			bit [RAD_W-1:0]  rad;
			if (pending_roots.size() == 0) begin
				report($sformatf("unexpected root 0x%04h", root));
			end else begin
				want = pending_roots.pop_front();
				rad = pending_rads.pop_front();
				if (root !== want) begin
					report($sformatf("radicand 0x%08h: root 0x%04h, expected 0x%04h",
						rad, root, want));
				end
			end
		endtask

		function int pending();
			return pending_roots.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [RAD_W-1:0]  s_tdata;   // [31:0] radicand
	logic              m_tvalid;
	logic              m_tready;
	logic [ROOT_W-1:0] m_tdata;   // [15:0] root

	root_scoreboard sb = new();
	bit quiet_src = 1'b0;
	bit quiet_snk = 1'b0;
	int idle_cycles = 0;

	integer_square_root_newton i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_input(s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task send_radicand(bit [RAD_W-1:0] radicand);
		int gap;
		gap = quiet_src ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= radicand;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	function bit [RAD_W-1:0] random_radicand();
		bit [31:0] r;
		bit [31:0] sq;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 1000);
			2: return $urandom() >> $urandom_range(0, 31);
			3: begin
				r = $urandom_range(0, 65535);
				sq = r * r;
				return sq + $urandom_range(0, 2) - 1;
			end
			default: return $urandom_range(32'h7000_0000, 32'hFFFF_FFFF);
		endcase
	endfunction

	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet_snk ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		bit [RAD_W-1:0] directed[$];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd15, 32'd16, 32'd17,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFE_0001,
			32'hFFFE_0000, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h3FFF_0001,
			32'd1000000, 32'd999999, 32'h0001_0000, 32'h0000_FFFF};
		foreach (directed[i]) send_radicand(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0) begin
				quiet_src = ($urandom_range(0, 3) == 0);
				quiet_snk = ($urandom_range(0, 3) == 0);
			end
			send_radicand(random_radicand());
		end
		s_tvalid <= 1'b0;
		quiet_snk = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (LINGER) @(posedge clk);

		if (sb.error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
